// ----- hw/rtl/edge_clipped_box_blur_3x3_defines.svh -----
// assertion macros for the edge-clipped 3x3 box blur
// no dependencies; taken in by the files that carry assertions
`ifndef EDGE_CLIPPED_BOX_BLUR_3X3_DEFINES_SVH
`define EDGE_CLIPPED_BOX_BLUR_3X3_DEFINES_SVH
`ifndef SYNTH
`define ECBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ECBB_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ECBB_ASSERT(lbl, clk, rst_n, prop, msg)
`define ECBB_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/ecbb_pkg.sv -----
// shared types, constants and the reciprocal table of the box blur
// no dependencies
package ecbb_pkg;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 24;
    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int X_W       = 13;
    localparam int RCP_W     = 18;
    localparam int RCP_SHIFT = 18;
    localparam int PROD_W    = X_W + RCP_W;
    localparam int CFG_W     = 12;
    localparam int APB_DW    = 32;
    localparam int APB_AW    = 3;
    localparam int Q_DEPTH   = 4;
    localparam int Q_AW      = 2;
    localparam int Q_CW      = 3;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DRAIN = 1'b1;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // one column of the window, indexed by row: 0 above, 1 centre, 2 below
    typedef logic [2:0][PIX_W-1:0] t_col;

    typedef struct packed {
        t_col [2:0] px;
        logic [2:0] row_ok;
        logic [2:0] col_ok;
        logic       emit_a;
        logic       emit_b;
        logic       col0_ok_b;
        logic       done;
    } t_job;

    typedef enum logic {
        PH_MAIN,
        PH_EDGE
    } t_phase;

    // ceil(2^17 / n): (2*sum + n) * rcp >> 18 is the rounded average
    function automatic logic [RCP_W-1:0] avg_rcp(input logic [CNT_W-1:0] n);
        logic [RCP_W-1:0] m;
        unique case (n)
            4'd0, 4'd1: m = 18'd131072;
            4'd2:       m = 18'd65536;
            4'd3:       m = 18'd43691;
            4'd4:       m = 18'd32768;
            4'd5:       m = 18'd26215;
            4'd6:       m = 18'd21846;
            4'd7:       m = 18'd18725;
            4'd8:       m = 18'd16384;
            4'd9:       m = 18'd14564;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

// ----- hw/rtl/ecbb_stream_if.sv -----
// request channels of the box blur: pixel/drain input and result output
// depends on ecbb_pkg
interface ecbb_in_if import ecbb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            kind;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;

    modport source (output valid, kind, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, kind, red_in, green_in, blue_in, output ready);
endinterface

interface ecbb_out_if import ecbb_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            last_of_run;
    logic            frame_done;

    modport source (output valid, red_out, green_out, blue_out, last_of_run, frame_done,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, last_of_run, frame_done,
                    output ready);
endinterface

// ----- hw/rtl/ecbb_front.sv -----
// front end: accepts requests, keeps raster counters, line stores and window
// depends on ecbb_pkg, ecbb_stream_if and the defines header
`include "edge_clipped_box_blur_3x3_defines.svh"

module ecbb_front import ecbb_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048,
    localparam int CW = $clog2(MAX_WIDTH + 1),
    localparam int RW = $clog2(MAX_HEIGHT + 1)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ecbb_in_if.sink         i_in,
    input  logic [CW-1:0]   i_width,
    input  logic [RW-1:0]   i_height,
    input  logic            i_restart,
    input  logic [Q_CW-1:0] i_free,
    output logic            o_push,
    output t_job            o_job
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    typedef struct packed {
        logic             pix_act;
        logic             drain_act;
        logic [AW-1:0]    addr;
        logic [PIX_W-1:0] pix;
        logic [2:0]       row_ok;
        logic [2:0]       col_ok;
        logic             emit_a;
        logic             emit_b;
        logic             col0_ok_b;
        logic             done;
    } t_op;

    logic [2*PIX_W-1:0] r_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd0, r_rd1, r_fwd_data;
    logic               r_fwd0, r_fwd1;
    logic               r_b_valid;
    t_op                r_op, n_op;
    t_col [2:0]         r_window, n_window;
    logic [CW-1:0]      r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RW-1:0]      r_in_row, n_in_row, r_out_row, n_out_row;

    logic               rdy, acc, is_pix, pix_ok, drain_ok, col_last, out_col_last;
    logic [CW:0]        in_col_p1, out_col_p1;
    logic [RW:0]        out_row_p1;
    logic [AW-1:0]      rd_addr0, rd_addr1;
    logic               wr_en;
    logic [2*PIX_W-1:0] wr_data, rd0_eff, rd1_eff;

    // stage a: accept and classify
    always_comb begin
        rdy          = r_b_valid ? (i_free > Q_CW'(1)) : (i_free != '0);
        acc          = i_in.valid && rdy;
        is_pix       = (i_in.kind == KIND_PIXEL);
        in_col_p1    = {1'b0, r_in_col} + (CW+1)'(1);
        out_col_p1   = {1'b0, r_out_col} + (CW+1)'(1);
        out_row_p1   = {1'b0, r_out_row} + (RW+1)'(1);
        col_last     = (in_col_p1 == {1'b0, i_width});
        out_col_last = (out_col_p1 == {1'b0, i_width});
        pix_ok       = is_pix && (r_in_row < i_height) && (r_in_col < i_width);
        drain_ok     = !is_pix && (r_in_row >= i_height)
                     && (out_row_p1 == {1'b0, i_height}) && (r_out_col < i_width);
        rd_addr0     = is_pix ? r_in_col[AW-1:0] : r_out_col[AW-1:0];
        rd_addr1     = out_col_p1[AW-1:0];

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_op      = '0;
        n_op.addr = rd_addr0;
        n_op.pix  = {i_in.red_in, i_in.green_in, i_in.blue_in};

        priority if (i_restart) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (acc && pix_ok) begin
            n_op.pix_act   = 1'b1;
            n_op.row_ok    = {1'b1, 1'b1, r_in_row > RW'(1)};
            n_op.col_ok    = {1'b1, 1'b1, r_in_col > CW'(1)};
            n_op.emit_a    = (r_in_row != '0) && (r_in_col != '0);
            n_op.emit_b    = (r_in_row != '0) && col_last;
            n_op.col0_ok_b = (r_in_col != '0);
            if (r_in_row != '0) begin
                if (col_last) begin
                    n_out_row = r_in_row;
                    n_out_col = '0;
                end else if (r_in_col != '0) begin
                    n_out_col = r_in_col;
                end
            end
            if (col_last) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
            end else begin
                n_in_col = in_col_p1[CW-1:0];
            end
        end else if (acc && drain_ok) begin
            n_op.drain_act = 1'b1;
            n_op.row_ok    = {1'b0, 1'b1, i_height > RW'(1)};
            n_op.col_ok    = {out_col_p1 < {1'b0, i_width}, 1'b1, r_out_col != '0};
            n_op.emit_a    = 1'b1;
            n_op.done      = out_col_last;
            if (out_col_last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end else begin
                n_out_col = out_col_p1[CW-1:0];
            end
        end else begin
            n_op.pix_act = 1'b0;
        end
    end

    // stage b: line store data in, window shift, job out
    always_comb begin
        rd0_eff  = r_fwd0 ? r_fwd_data : r_rd0;
        rd1_eff  = r_fwd1 ? r_fwd_data : r_rd1;
        wr_en    = r_b_valid && r_op.pix_act;
        wr_data  = {rd0_eff[PIX_W-1:0], r_op.pix};
        n_window = r_window;
        if (r_op.pix_act) begin
            n_window[0] = r_window[1];
            n_window[1] = r_window[2];
            n_window[2] = {r_op.pix, rd0_eff[PIX_W-1:0], rd0_eff[2*PIX_W-1:PIX_W]};
        end else if (r_op.drain_act) begin
            n_window[0] = r_window[1];
            n_window[1] = {{PIX_W{1'b0}}, rd0_eff[PIX_W-1:0], rd0_eff[2*PIX_W-1:PIX_W]};
            n_window[2] = {{PIX_W{1'b0}}, rd1_eff[PIX_W-1:0], rd1_eff[2*PIX_W-1:PIX_W]};
        end
        o_push          = r_b_valid && (r_op.emit_a || r_op.emit_b);
        o_job.px        = n_window;
        o_job.row_ok    = r_op.row_ok;
        o_job.col_ok    = r_op.col_ok;
        o_job.emit_a    = r_op.emit_a;
        o_job.emit_b    = r_op.emit_b;
        o_job.col0_ok_b = r_op.col0_ok_b;
        o_job.done      = r_op.done;
    end

    assign i_in.ready = rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd0    <= 1'b0;
            r_fwd1    <= 1'b0;
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_b_valid <= acc;
            r_fwd0    <= acc && wr_en && (r_op.addr == rd_addr0);
            r_fwd1    <= acc && wr_en && (r_op.addr == rd_addr1);
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_fwd_data <= wr_data;
        if (r_b_valid) begin
            r_window <= n_window;
        end
    end

    // line stores: older row in the upper half, newer row in the lower half
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd0 <= r_mem[rd_addr0];
            r_rd1 <= r_mem[rd_addr1];
        end
        if (wr_en) begin
            r_mem[r_op.addr] <= wr_data;
        end
    end

    `ECBB_ASSERT(a_col_in_frame, i_clk, i_rst_n, r_in_col < i_width, "input column out of frame")
    `ECBB_ASSERT(a_fwd_has_item, i_clk, i_rst_n, (r_fwd0 || r_fwd1) |-> r_b_valid, "forward without item")

endmodule

// ----- hw/rtl/ecbb_queue.sv -----
// short job queue between the front end and the averaging back end
// depends on ecbb_pkg and the defines header
`include "edge_clipped_box_blur_3x3_defines.svh"

module ecbb_queue import ecbb_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  t_job            i_job,
    input  logic            i_pop,
    output logic            o_valid,
    output t_job            o_head,
    output logic [Q_CW-1:0] o_free
);

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [Q_CW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_free  = Q_CW'(Q_DEPTH) - r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + Q_CW'(1);
                2'b01:   r_count <= r_count - Q_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `ECBB_ASSERT(a_no_overflow, i_clk, i_rst_n, !(i_push && !i_pop && r_count == Q_CW'(Q_DEPTH)), "queue overflow")
    `ECBB_ASSERT(a_no_underflow, i_clk, i_rst_n, i_pop |-> o_valid, "queue underflow")

endmodule

// ----- hw/rtl/ecbb_back.sv -----
// back end: neighbor sums, reciprocal multiply and the output register
// depends on ecbb_pkg, ecbb_stream_if and the defines header
`include "edge_clipped_box_blur_3x3_defines.svh"

module ecbb_back import ecbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_job    i_head,
    output logic    o_pop,
    ecbb_out_if.source o_out
);

    t_phase                        r_phase, n_phase;
    logic                          en, use_b, take;
    t_col [2:0]                    sel;
    logic [2:0]                    ok;
    logic [2:0][SUM_W-1:0]         sum;
    logic [CNT_W-1:0]              cnt;
    logic [2:0][X_W-1:0]           x;
    logic [RCP_W-1:0]              rcp;

    logic                          r_s1_valid, r_s2_valid, r_o_valid;
    logic [2:0][SUM_W-1:0]         r_s1_sum;
    logic [CNT_W-1:0]              r_s1_cnt;
    logic                          r_s1_last, r_s1_done;
    logic [2:0][PROD_W-1:0]        r_s2_prod;
    logic                          r_s2_last, r_s2_done;
    logic [2:0][CH_W-1:0]          r_o_rgb;
    logic                          r_o_last, r_o_done;

    always_comb begin
        en    = !r_o_valid || o_out.ready;
        use_b = (r_phase == PH_EDGE) || !i_head.emit_a;
        take  = en && i_q_valid;
        o_pop = take && (use_b || !i_head.emit_b);
        if (use_b) begin
            sel = {{3*PIX_W{1'b0}}, i_head.px[2], i_head.px[1]};
            ok  = {1'b0, 1'b1, i_head.col0_ok_b};
        end else begin
            sel = i_head.px;
            ok  = i_head.col_ok;
        end
        sum = '0;
        cnt = '0;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (ok[c] && i_head.row_ok[r]) begin
                    for (int ch = 0; ch < 3; ch++) begin
                        sum[ch] = sum[ch] + SUM_W'(sel[c][r][ch*CH_W +: CH_W]);
                    end
                    cnt = cnt + CNT_W'(1);
                end
            end
        end
        rcp = avg_rcp(r_s1_cnt);
        for (int ch = 0; ch < 3; ch++) begin
            x[ch] = {r_s1_sum[ch], 1'b0} + X_W'(r_s1_cnt);
        end
    end

    always_comb begin
        n_phase = r_phase;
        if (take) begin
            if (use_b) begin
                n_phase = PH_MAIN;
            end else if (i_head.emit_b) begin
                n_phase = PH_EDGE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAIN;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            if (en) begin
                r_s1_valid <= take;
                r_s2_valid <= r_s1_valid;
                r_o_valid  <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_sum  <= sum;
            r_s1_cnt  <= cnt;
            r_s1_last <= use_b || !i_head.emit_b;
            r_s1_done <= i_head.done;
            for (int ch = 0; ch < 3; ch++) begin
                r_s2_prod[ch] <= PROD_W'(x[ch]) * PROD_W'(rcp);
                r_o_rgb[ch]   <= r_s2_prod[ch][RCP_SHIFT +: CH_W];
            end
            r_s2_last <= r_s1_last;
            r_s2_done <= r_s1_done;
            r_o_last  <= r_s2_last;
            r_o_done  <= r_s2_done;
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.red_out     = r_o_rgb[2];
    assign o_out.green_out   = r_o_rgb[1];
    assign o_out.blue_out    = r_o_rgb[0];
    assign o_out.last_of_run = r_o_last;
    assign o_out.frame_done  = r_o_done;

    `ECBB_ASSERT_RST(a_reset_clears_out, i_clk, !i_rst_n |=> !r_o_valid, "output valid after reset")
    `ECBB_ASSERT(a_done_is_last, i_clk, i_rst_n, (r_o_valid && r_o_done) |-> r_o_last, "frame done not last")
    `ECBB_ASSERT(a_edge_has_job, i_clk, i_rst_n, (r_phase == PH_EDGE) |-> i_q_valid, "edge phase without job")

endmodule

// ----- hw/rtl/edge_clipped_box_blur_3x3.sv -----
// top level of the edge-clipped 3x3 box blur: config registers and the three parts
// depends on ecbb_pkg, ecbb_stream_if, ecbb_front, ecbb_queue, ecbb_back
//
// i_in takes one request per cycle while i_in.ready is high: kind pixel carries
// an RGB pixel in raster order, kind drain flushes one pending output of the last
// row. o_out gives the rounded average of each pixel's in-frame 3x3 neighbors, one
// row behind the input. A pixel releases up to two results (two at a row end);
// after the last pixel, frame_width drains give the last row, and frame_done marks
// the final one. Requests that release nothing are absorbed without a result.
// A job goes from front-end stage b through the queue to the back end's sum,
// product and output registers. Throughput: one request per cycle while ready is
// high; a row-end job feeds two results, absorbed by the four-entry job queue.
// The APB port sets frame_width (address 0) and frame_height (address 4);
// a write restarts the raster counters. pready is always high.
// Reset: counters at zero, both dimensions at 2048 (or the maximum), queue and
// pipeline empty; the line stores are not cleared, unwritten entries are masked.
// When o_out stalls, the output register holds, the back end stops, the queue
// fills and i_in.ready drops once no slot is free, or one with a job in stage b.
module edge_clipped_box_blur_3x3 import ecbb_pkg::*; #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ecbb_in_if.sink           i_in,
    ecbb_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int CW      = $clog2(MAX_WIDTH + 1);
    localparam int RW      = $clog2(MAX_HEIGHT + 1);
    localparam int RESET_W = (MAX_WIDTH < 2048) ? MAX_WIDTH : 2048;
    localparam int RESET_H = (MAX_HEIGHT < 2048) ? MAX_HEIGHT : 2048;

    logic [CW-1:0]   r_width, n_width;
    logic [RW-1:0]   r_height, n_height;
    logic            wr;
    logic [31:0]     wv;
    logic            push, pop, q_valid;
    t_job            job, head;
    logic [Q_CW-1:0] free;

    always_comb begin
        wr       = psel && penable && pwrite;
        wv       = 32'(pwdata[CFG_W-1:0]);
        n_width  = r_width;
        n_height = r_height;
        if (wr) begin
            unique case (paddr[2])
                REG_FRAME_WIDTH: begin
                    if (wv == '0) begin
                        n_width = CW'(1);
                    end else if (wv > 32'(MAX_WIDTH)) begin
                        n_width = CW'(MAX_WIDTH);
                    end else begin
                        n_width = CW'(wv);
                    end
                end
                REG_FRAME_HEIGHT: begin
                    if (wv == '0) begin
                        n_height = RW'(1);
                    end else if (wv > 32'(MAX_HEIGHT)) begin
                        n_height = RW'(MAX_HEIGHT);
                    end else begin
                        n_height = RW'(wv);
                    end
                end
                default: n_width = r_width;
            endcase
        end
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = APB_DW'(r_width);
            REG_FRAME_HEIGHT: prdata = APB_DW'(r_height);
            default:          prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= CW'(RESET_W);
            r_height <= RW'(RESET_H);
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    ecbb_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_restart (wr),
        .i_free    (free),
        .o_push    (push),
        .o_job     (job)
    );

    ecbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_head  (head),
        .o_free  (free)
    );

    ecbb_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_head    (head),
        .o_pop     (pop),
        .o_out     (o_out)
    );

endmodule
